/* rtl/core/cpcr_pkg.sv */
// Shared constants for the circle pair collision response core.
// No dependencies; imported by every module of the core.
package cpcr_pkg;

    localparam int DEF_COORD_WIDTH = 24;
    localparam int AXIS_BITS       = 14;
    localparam int QUOT_BITS       = AXIS_BITS + 1;
    localparam int BOUNCE_W        = 15;
    localparam logic [BOUNCE_W-1:0] BOUNCE_RESET = 15'd16384;
    localparam int CFG_AW          = 3;
    localparam logic REG_BOUNCE    = 1'b0;

endpackage

/* rtl/core/circle_pair_collision_response_core.sv */
// Top level of the circle pair collision response core: ports, register and pipeline.
// Depends on cpcr_pkg and cpcr_axis.
//
// Channel | Handshake                          | Word
// input   | start, busy                        | two circles: centre, velocity, radius, fixed
// result  | o_done strobe, one cycle           | new velocities, touching, responded
// config  | psel, penable, pwrite, pready      | bounciness at byte address 0
//
// One pair is taken in every cycle; busy is always low.
// A result is registered through stages 1 and 2, the one-bit-per-stage square root, the
// fifteen-stage axis dividers and stages M1 to M4, in that order.
// Reset clears the valid bits and sets bounciness to 1.0.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module circle_pair_collision_response_core import cpcr_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_a_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_y,
    input  logic signed [COORD_WIDTH-1:0] i_a_vx,
    input  logic signed [COORD_WIDTH-1:0] i_a_vy,
    input  logic [COORD_WIDTH-2:0]        i_a_radius,
    input  logic                          i_a_fixed,
    input  logic signed [COORD_WIDTH-1:0] i_b_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_y,
    input  logic signed [COORD_WIDTH-1:0] i_b_vx,
    input  logic signed [COORD_WIDTH-1:0] i_b_vy,
    input  logic [COORD_WIDTH-2:0]        i_b_radius,
    input  logic                          i_b_fixed,
    output logic                          o_done,
    output logic signed [COORD_WIDTH-1:0] o_new_a_vx,
    output logic signed [COORD_WIDTH-1:0] o_new_a_vy,
    output logic signed [COORD_WIDTH-1:0] o_new_b_vx,
    output logic signed [COORD_WIDTH-1:0] o_new_b_vy,
    output logic                          o_touching,
    output logic                          o_responded,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [CFG_AW-1:0]             paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int W   = COORD_WIDTH;
    localparam int GS  = (W > 31) ? W - 31 : 0;
    localparam int DW  = W + 1 - GS;
    localparam int XW  = W + 2;
    localparam int RSW = W - GS;
    localparam int SQW = 2 * DW;
    localparam int QB  = QUOT_BITS;
    localparam int AXL = 1 + DW + QB;
    localparam int PW  = W + 1 + QB + 1;
    localparam int SW  = PW + 1;
    localparam int UW  = 2 * (QB + 1) + 1;
    localparam int TW  = UW - AXIS_BITS;
    localparam int SSW = SW - AXIS_BITS;
    localparam int MW  = TW + SSW;
    localparam int DLW = MW - AXIS_BITS;
    localparam int VW  = DLW + 1;

    typedef struct packed {
        logic signed [W-1:0] avx;
        logic signed [W-1:0] avy;
        logic signed [W-1:0] bvx;
        logic signed [W-1:0] bvy;
        logic signed [W:0]   dvx;
        logic signed [W:0]   dvy;
        logic                afix;
        logic                bfix;
        logic                hit;
    } t_ctx;

    // Configuration register.
    logic [BOUNCE_W-1:0] r_bounce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounce <= BOUNCE_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_BOUNCE) begin
            r_bounce <= pwdata[BOUNCE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BOUNCE) ? 32'(r_bounce) : '0;
    assign busy   = 1'b0;

    // Stage 1: box reject, centre difference, radius sum.
    logic signed [XW-1:0] w_ax, w_ay, w_bx, w_by, w_ar, w_br, w_dxw, w_dyw, w_dxs, w_dys;
    logic signed [XW-1:0] w_bias_x, w_bias_y;
    logic [W-1:0]         w_rsum;
    logic                 w_far;

    assign w_ax  = XW'(i_a_x);
    assign w_ay  = XW'(i_a_y);
    assign w_bx  = XW'(i_b_x);
    assign w_by  = XW'(i_b_y);
    assign w_ar  = signed'(XW'(i_a_radius));
    assign w_br  = signed'(XW'(i_b_radius));
    assign w_far = (w_ax - w_ar > w_bx + w_br) || (w_ax + w_ar < w_bx - w_br) ||
                   (w_ay - w_ar > w_by + w_br) || (w_ay + w_ar < w_by - w_br);
    assign w_dxw = w_bx - w_ax;
    assign w_dyw = w_by - w_ay;
    assign w_bias_x = w_dxw[XW-1] ? signed'(XW'((64'd1 << GS) - 64'd1)) : '0;
    assign w_bias_y = w_dyw[XW-1] ? signed'(XW'((64'd1 << GS) - 64'd1)) : '0;
    assign w_dxs = (w_dxw + w_bias_x) >>> GS;
    assign w_dys = (w_dyw + w_bias_y) >>> GS;
    assign w_rsum = W'({1'b0, i_a_radius} + {1'b0, i_b_radius});

    logic                 r_s1_vld, r_s1_far;
    logic signed [DW-1:0] r_s1_dx, r_s1_dy;
    logic [RSW-1:0]       r_s1_rs;
    t_ctx                 r_s1_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
        end
        r_s1_far      <= w_far;
        r_s1_dx       <= w_dxs[DW-1:0];
        r_s1_dy       <= w_dys[DW-1:0];
        r_s1_rs       <= RSW'(w_rsum >> GS);
        r_s1_ctx.avx  <= i_a_vx;
        r_s1_ctx.avy  <= i_a_vy;
        r_s1_ctx.bvx  <= i_b_vx;
        r_s1_ctx.bvy  <= i_b_vy;
        r_s1_ctx.dvx  <= (W+1)'(i_a_vx) - (W+1)'(i_b_vx);
        r_s1_ctx.dvy  <= (W+1)'(i_a_vy) - (W+1)'(i_b_vy);
        r_s1_ctx.afix <= i_a_fixed;
        r_s1_ctx.bfix <= i_b_fixed;
        r_s1_ctx.hit  <= 1'b0;
    end

    // Stage 2: squares.
    logic                  r_s2_vld, r_s2_far;
    logic signed [SQW-1:0] r_s2_dxsq, r_s2_dysq;
    logic [2*RSW-1:0]      r_s2_rssq;
    logic signed [DW-1:0]  r_s2_dx, r_s2_dy;
    t_ctx                  r_s2_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_far  <= r_s1_far;
        r_s2_dxsq <= SQW'(r_s1_dx) * SQW'(r_s1_dx);
        r_s2_dysq <= SQW'(r_s1_dy) * SQW'(r_s1_dy);
        r_s2_rssq <= (2*RSW)'(r_s1_rs) * (2*RSW)'(r_s1_rs);
        r_s2_dx   <= r_s1_dx;
        r_s2_dy   <= r_s1_dy;
        r_s2_ctx  <= r_s1_ctx;
    end

    // Distance test, then the axis unit and the matching delay line.
    logic [SQW-1:0] w_dsq;
    t_ctx           w_s3_ctx;

    assign w_dsq = SQW'(r_s2_dxsq) + SQW'(r_s2_dysq);

    always_comb begin
        w_s3_ctx     = r_s2_ctx;
        w_s3_ctx.hit = !r_s2_far && (w_dsq != '0) && (w_dsq <= SQW'(r_s2_rssq));
    end

    logic signed [QB:0] w_axis_x, w_axis_y;

    cpcr_axis #(
        .DW(DW)
    ) u_axis (
        .i_clk (i_clk),
        .i_dsq (w_dsq),
        .i_dx  (r_s2_dx),
        .i_dy  (r_s2_dy),
        .o_ax  (w_axis_x),
        .o_ay  (w_axis_y)
    );

    t_ctx r_dl_ctx [0:AXL-1];
    logic r_dl_vld [0:AXL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXL; i++) begin
                r_dl_vld[i] <= 1'b0;
            end
        end else begin
            r_dl_vld[0] <= r_s2_vld;
            for (int i = 1; i < AXL; i++) begin
                r_dl_vld[i] <= r_dl_vld[i-1];
            end
        end
        r_dl_ctx[0] <= w_s3_ctx;
        for (int i = 1; i < AXL; i++) begin
            r_dl_ctx[i] <= r_dl_ctx[i-1];
        end
    end

    // Stage M1: projections and scaled axis.
    logic                 r_m1_vld;
    logic signed [PW-1:0] r_m1_px, r_m1_py;
    logic signed [UW-1:0] r_m1_ux, r_m1_uy;
    t_ctx                 r_m1_ctx;
    t_ctx                 w_dl_out;
    logic signed [QB:0]   w_bnc;
    logic signed [UW-1:0] w_ux, w_uy;

    assign w_dl_out = r_dl_ctx[AXL-1];
    assign w_bnc    = signed'({1'b0, r_bounce});
    assign w_ux     = UW'(w_axis_x * w_bnc);
    assign w_uy     = UW'(w_axis_y * w_bnc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
        end else begin
            r_m1_vld <= r_dl_vld[AXL-1];
        end
        r_m1_px  <= PW'(w_dl_out.dvx) * PW'(w_axis_x);
        r_m1_py  <= PW'(w_dl_out.dvy) * PW'(w_axis_y);
        r_m1_ux  <= (w_dl_out.afix || w_dl_out.bfix) ? (w_ux <<< 1) : w_ux;
        r_m1_uy  <= (w_dl_out.afix || w_dl_out.bfix) ? (w_uy <<< 1) : w_uy;
        r_m1_ctx <= w_dl_out;
    end

    // Stage M2: approach sum and truncated axis factors.
    logic                 r_m2_vld;
    logic signed [SW-1:0] r_m2_sum;
    logic signed [TW-1:0] r_m2_ux, r_m2_uy;
    t_ctx                 r_m2_ctx;
    logic signed [UW-1:0] w_ux_b, w_uy_b, w_ux_t, w_uy_t;

    assign w_ux_b = r_m1_ux[UW-1] ? signed'(UW'((1 << AXIS_BITS) - 1)) : '0;
    assign w_uy_b = r_m1_uy[UW-1] ? signed'(UW'((1 << AXIS_BITS) - 1)) : '0;
    assign w_ux_t = (r_m1_ux + w_ux_b) >>> AXIS_BITS;
    assign w_uy_t = (r_m1_uy + w_uy_b) >>> AXIS_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_vld <= 1'b0;
        end else begin
            r_m2_vld <= r_m1_vld;
        end
        r_m2_sum <= SW'(r_m1_px) + SW'(r_m1_py);
        r_m2_ux  <= w_ux_t[TW-1:0];
        r_m2_uy  <= w_uy_t[TW-1:0];
        r_m2_ctx <= r_m1_ctx;
    end

    // Stage M3: products with the approach speed.
    logic                  r_m3_vld, r_m3_pos;
    logic signed [MW-1:0]  r_m3_px, r_m3_py;
    t_ctx                  r_m3_ctx;
    logic signed [SSW-1:0] w_speed;
    logic signed [SW-1:0]  w_sum_sh;

    assign w_sum_sh = r_m2_sum >>> AXIS_BITS;
    assign w_speed  = w_sum_sh[SSW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3_vld <= 1'b0;
        end else begin
            r_m3_vld <= r_m2_vld;
        end
        r_m3_pos <= !r_m2_sum[SW-1] && (r_m2_sum != '0);
        r_m3_px  <= MW'(r_m2_ux) * MW'(w_speed);
        r_m3_py  <= MW'(r_m2_uy) * MW'(w_speed);
        r_m3_ctx <= r_m2_ctx;
    end

    // Stage M4: deltas, update and saturation.
    function automatic logic [W-1:0] f_sat(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] hi, lo;
        hi = signed'(VW'((64'd1 << (W - 1)) - 64'd1));
        lo = -hi - VW'(1);
        if (v > hi) begin
            return hi[W-1:0];
        end else if (v < lo) begin
            return lo[W-1:0];
        end
        return v[W-1:0];
    endfunction

    logic signed [MW-1:0]  w_px_b, w_py_b, w_px_t, w_py_t;
    logic signed [DLW-1:0] w_ddx, w_ddy;
    logic                  w_resp;

    assign w_px_b = r_m3_px[MW-1] ? signed'(MW'((1 << AXIS_BITS) - 1)) : '0;
    assign w_py_b = r_m3_py[MW-1] ? signed'(MW'((1 << AXIS_BITS) - 1)) : '0;
    assign w_px_t = (r_m3_px + w_px_b) >>> AXIS_BITS;
    assign w_py_t = (r_m3_py + w_py_b) >>> AXIS_BITS;
    assign w_ddx  = w_px_t[DLW-1:0];
    assign w_ddy  = w_py_t[DLW-1:0];
    assign w_resp = r_m3_ctx.hit && r_m3_pos && !(r_m3_ctx.afix && r_m3_ctx.bfix);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_m3_vld;
        end
        o_touching  <= r_m3_ctx.hit;
        o_responded <= w_resp;
        o_new_a_vx  <= (w_resp && !r_m3_ctx.afix) ?
                       f_sat(VW'(r_m3_ctx.avx) - VW'(w_ddx)) : r_m3_ctx.avx;
        o_new_a_vy  <= (w_resp && !r_m3_ctx.afix) ?
                       f_sat(VW'(r_m3_ctx.avy) - VW'(w_ddy)) : r_m3_ctx.avy;
        o_new_b_vx  <= (w_resp && !r_m3_ctx.bfix) ?
                       f_sat(VW'(r_m3_ctx.bvx) + VW'(w_ddx)) : r_m3_ctx.bvx;
        o_new_b_vy  <= (w_resp && !r_m3_ctx.bfix) ?
                       f_sat(VW'(r_m3_ctx.bvy) + VW'(w_ddy)) : r_m3_ctx.bvy;
    end

endmodule

/* rtl/core/cpcr_axis.sv */
// Pipelined integer square root and two restoring dividers giving the unit axis.
// Depends on cpcr_pkg for the axis scale.
module cpcr_axis import cpcr_pkg::*; #(
    parameter int DW = DEF_COORD_WIDTH + 1
) (
    input  logic                 i_clk,
    input  logic [2*DW-1:0]      i_dsq,
    input  logic signed [DW-1:0] i_dx,
    input  logic signed [DW-1:0] i_dy,
    output logic signed [QUOT_BITS:0] o_ax,
    output logic signed [QUOT_BITS:0] o_ay
);

    localparam int RW = DW;
    localparam int TW = 2 * DW + 1;
    localparam int QB = QUOT_BITS;
    localparam int NW = DW + AXIS_BITS + 1;

    logic [TW-1:0]        r_rem [0:RW];
    logic [RW-1:0]        r_sq  [0:RW];
    logic signed [DW-1:0] r_sdx [0:RW];
    logic signed [DW-1:0] r_sdy [0:RW];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= TW'(i_dsq);
        r_sq[0]  <= '0;
        r_sdx[0] <= i_dx;
        r_sdy[0] <= i_dy;
    end

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        localparam int B = RW - 1 - k;
        logic [TW-1:0] c_trial;
        assign c_trial = (TW'(r_sq[k]) << (B + 1)) + (TW'(1) << (2 * B));
        always_ff @(posedge i_clk) begin
            if (r_rem[k] >= c_trial) begin
                r_rem[k+1] <= r_rem[k] - c_trial;
                r_sq[k+1]  <= r_sq[k] | (RW'(1) << B);
            end else begin
                r_rem[k+1] <= r_rem[k];
                r_sq[k+1]  <= r_sq[k];
            end
            r_sdx[k+1] <= r_sdx[k];
            r_sdy[k+1] <= r_sdy[k];
        end
    end

    logic [DW-1:0] w_mag_x, w_mag_y;
    assign w_mag_x = r_sdx[RW][DW-1] ? DW'(-r_sdx[RW]) : DW'(r_sdx[RW]);
    assign w_mag_y = r_sdy[RW][DW-1] ? DW'(-r_sdy[RW]) : DW'(r_sdy[RW]);

    logic [NW-1:0] r_drx  [0:QB-1];
    logic [NW-1:0] r_dry  [0:QB-1];
    logic [QB-1:0] r_dqx  [0:QB-1];
    logic [QB-1:0] r_dqy  [0:QB-1];
    logic [RW-1:0] r_dist [0:QB-1];
    logic          r_dnx  [0:QB-1];
    logic          r_dny  [0:QB-1];

    for (genvar k = 0; k < QB; k++) begin : g_div
        localparam int J = QB - 1 - k;
        logic [NW-1:0] c_rx, c_ry, c_tst;
        logic [QB-1:0] c_qx, c_qy;
        logic [RW-1:0] c_dist;
        logic          c_nx, c_ny;
        if (k == 0) begin : g_first
            assign c_rx   = NW'(w_mag_x) << AXIS_BITS;
            assign c_ry   = NW'(w_mag_y) << AXIS_BITS;
            assign c_qx   = '0;
            assign c_qy   = '0;
            assign c_dist = r_sq[RW];
            assign c_nx   = r_sdx[RW][DW-1];
            assign c_ny   = r_sdy[RW][DW-1];
        end else begin : g_next
            assign c_rx   = r_drx[k-1];
            assign c_ry   = r_dry[k-1];
            assign c_qx   = r_dqx[k-1];
            assign c_qy   = r_dqy[k-1];
            assign c_dist = r_dist[k-1];
            assign c_nx   = r_dnx[k-1];
            assign c_ny   = r_dny[k-1];
        end
        assign c_tst = NW'(c_dist) << J;
        always_ff @(posedge i_clk) begin
            if (c_rx >= c_tst) begin
                r_drx[k] <= c_rx - c_tst;
                r_dqx[k] <= c_qx | (QB'(1) << J);
            end else begin
                r_drx[k] <= c_rx;
                r_dqx[k] <= c_qx;
            end
            if (c_ry >= c_tst) begin
                r_dry[k] <= c_ry - c_tst;
                r_dqy[k] <= c_qy | (QB'(1) << J);
            end else begin
                r_dry[k] <= c_ry;
                r_dqy[k] <= c_qy;
            end
            r_dist[k] <= c_dist;
            r_dnx[k]  <= c_nx;
            r_dny[k]  <= c_ny;
        end
    end

    assign o_ax = r_dnx[QB-1] ? -signed'({1'b0, r_dqx[QB-1]}) : signed'({1'b0, r_dqx[QB-1]});
    assign o_ay = r_dny[QB-1] ? -signed'({1'b0, r_dqy[QB-1]}) : signed'({1'b0, r_dqy[QB-1]});

endmodule

/* rtl/core/cpcr_checker.sv */
// Port-level checks for the circle pair collision response core, with its bind.
// Depends on cpcr_pkg and on the top level's port names.
module cpcr_checker import cpcr_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          i_a_fixed,
    input logic signed [COORD_WIDTH-1:0] i_a_vx,
    input logic signed [COORD_WIDTH-1:0] i_b_vy,
    input logic                          o_done,
    input logic signed [COORD_WIDTH-1:0] o_new_a_vx,
    input logic signed [COORD_WIDTH-1:0] o_new_b_vy,
    input logic                          o_touching,
    input logic                          o_responded
);

    localparam int GS  = (COORD_WIDTH > 31) ? COORD_WIDTH - 31 : 0;
    localparam int LAT = 7 + (COORD_WIDTH + 1 - GS) + QUOT_BITS;

    a_word_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LAT o_done)
        else $error("Result word missing at the fixed latency.");

    a_resp_needs_touch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_responded |-> o_touching)
        else $error("Response reported without contact.");

    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_responded |->
            o_new_a_vx == $past(i_a_vx, LAT) && o_new_b_vy == $past(i_b_vy, LAT))
        else $error("Velocities changed without a response.");

    a_fixed_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && $past(i_a_fixed, LAT) |-> o_new_a_vx == $past(i_a_vx, LAT))
        else $error("Fixed circle velocity changed.");

endmodule

bind circle_pair_collision_response_core cpcr_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_cpcr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_a_fixed   (i_a_fixed),
    .i_a_vx      (i_a_vx),
    .i_b_vy      (i_b_vy),
    .o_done      (o_done),
    .o_new_a_vx  (o_new_a_vx),
    .o_new_b_vy  (o_new_b_vy),
    .o_touching  (o_touching),
    .o_responded (o_responded)
);

/* verif/circle_pair_collision_response_core_tb.sv */
// Self-checking testbench for the circle pair collision response core.
// Drives circle pairs and APB writes of bounciness, predicts each result word in place.
// Depends on cpcr_pkg and circle_pair_collision_response_core.
`timescale 1ns / 100ps

module circle_pair_collision_response_core_tb;
    import cpcr_pkg::*;

    localparam int W = DEF_COORD_WIDTH;
    localparam int LATENCY = W + 23;
    localparam int AXIS_ONE = 16384;

    typedef struct {
        logic signed [W-1:0] ax, ay, avx, avy, bx, by, bvx, bvy;
        logic [W-2:0]        ar, br;
        logic                afix, bfix;
    } pair_t;

    typedef struct {
        logic signed [W-1:0] navx, navy, nbvx, nbvy;
        logic                touch, resp;
    } response_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [W-1:0] i_a_x = '0, i_a_y = '0, i_a_vx = '0, i_a_vy = '0;
    logic signed [W-1:0] i_b_x = '0, i_b_y = '0, i_b_vx = '0, i_b_vy = '0;
    logic [W-2:0] i_a_radius = '0, i_b_radius = '0;
    logic i_a_fixed = 1'b0, i_b_fixed = 1'b0;
    logic o_done, o_touching, o_responded;
    logic signed [W-1:0] o_new_a_vx, o_new_a_vy, o_new_b_vx, o_new_b_vy;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    pair_t     pending_pairs[$];
    response_t expected_responses[$];
    logic [BOUNCE_W-1:0] bounce_model = BOUNCE_RESET;
    int errors = 0;
    int words_checked = 0;
    int touches_seen = 0;
    int responses_seen = 0;
    bit driver_on = 1'b0;
    int burst_left = 0;
    int gap_left = 0;

    circle_pair_collision_response_core DUT (.*);

    always #6 i_clk = ~i_clk;

    function automatic longint isqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint along_axis(longint axc, longint s, longint m);
        longint u;
        u = (axc * longint'(bounce_model) * m) / AXIS_ONE;
        return (u * s) / AXIS_ONE;
    endfunction

    function automatic logic signed [W-1:0] clamp(longint v);
        longint hi, lo;
        hi = (longint'(1) <<< (W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[W-1:0];
    endfunction

    function automatic response_t collide(pair_t p);
        response_t res;
        longint axp, ayp, avx, avy, ar, bxp, byp, bvx, bvy, br;
        longint nax, nay, nbx, nby, dx, dy, rs, dlen, axx, axy, sum, s, ddx, ddy;
        longint unsigned dsq, rsq;
        bit far;
        axp = p.ax; ayp = p.ay; avx = p.avx; avy = p.avy; ar = p.ar;
        bxp = p.bx; byp = p.by; bvx = p.bvx; bvy = p.bvy; br = p.br;
        nax = avx; nay = avy; nbx = bvx; nby = bvy;
        res.touch = 1'b0;
        res.resp = 1'b0;
        far = (axp - ar > bxp + br) || (axp + ar < bxp - br) ||
              (ayp - ar > byp + br) || (ayp + ar < byp - br);
        if (!far) begin
            dx = bxp - axp;
            dy = byp - ayp;
            rs = ar + br;
            dsq = longint'(dx * dx) + longint'(dy * dy);
            rsq = rs * rs;
            if (dsq > 0 && dsq <= rsq) begin
                dlen = isqrt(dsq);
                axx = (dx * AXIS_ONE) / dlen;
                axy = (dy * AXIS_ONE) / dlen;
                sum = (avx - bvx) * axx + (avy - bvy) * axy;
                res.touch = 1'b1;
                if (sum > 0) begin
                    s = sum / AXIS_ONE;
                    if (!p.afix && !p.bfix) begin
                        ddx = along_axis(axx, s, 1);
                        ddy = along_axis(axy, s, 1);
                        nax = avx - ddx; nay = avy - ddy;
                        nbx = bvx + ddx; nby = bvy + ddy;
                        res.resp = 1'b1;
                    end else if (!p.afix) begin
                        nax = avx - along_axis(axx, s, 2);
                        nay = avy - along_axis(axy, s, 2);
                        res.resp = 1'b1;
                    end else if (!p.bfix) begin
                        nbx = bvx + along_axis(axx, s, 2);
                        nby = bvy + along_axis(axy, s, 2);
                        res.resp = 1'b1;
                    end
                end
            end
        end
        res.navx = clamp(nax);
        res.navy = clamp(nay);
        res.nbvx = clamp(nbx);
        res.nbvy = clamp(nby);
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Driver: bursts of back-to-back pairs separated by random gaps.
    always @(posedge i_clk) begin
        pair_t p;
        if (start && !busy) begin
            expected_responses.push_back(collide(pending_pairs.pop_front()));
        end
        if (!driver_on || pending_pairs.size() == 0) begin
            start <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
        end else begin
            p = pending_pairs[0];
            if (burst_left == 0) begin
                burst_left = $urandom_range(40, 1);
                gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
                start <= 1'b0;
            end else begin
                burst_left--;
                start <= 1'b1;
                i_a_x <= p.ax; i_a_y <= p.ay; i_a_vx <= p.avx; i_a_vy <= p.avy;
                i_a_radius <= p.ar; i_a_fixed <= p.afix;
                i_b_x <= p.bx; i_b_y <= p.by; i_b_vx <= p.bvx; i_b_vy <= p.bvy;
                i_b_radius <= p.br; i_b_fixed <= p.bfix;
            end
        end
    end

    // Monitor: every strobed word must match the oldest prediction.
    always @(posedge i_clk) begin
        response_t e;
        if (i_rst_n && o_done) begin
            if (expected_responses.size() == 0) begin
                report_mismatch("unexpected word", 0, 0);
            end else begin
                e = expected_responses.pop_front();
                words_checked++;
                if (e.touch) touches_seen++;
                if (e.resp) responses_seen++;
                if (o_new_a_vx !== e.navx) report_mismatch("new_a_vx", o_new_a_vx, e.navx);
                if (o_new_a_vy !== e.navy) report_mismatch("new_a_vy", o_new_a_vy, e.navy);
                if (o_new_b_vx !== e.nbvx) report_mismatch("new_b_vx", o_new_b_vx, e.nbvx);
                if (o_new_b_vy !== e.nbvy) report_mismatch("new_b_vy", o_new_b_vy, e.nbvy);
                if (o_touching !== e.touch) report_mismatch("touching", o_touching, e.touch);
                if (o_responded !== e.resp) report_mismatch("responded", o_responded, e.resp);
            end
        end
    end

    function automatic logic signed [W-1:0] rand_word();
        return W'($urandom);
    endfunction

    function automatic logic signed [W-1:0] near(logic signed [W-1:0] c, int span);
        longint v;
        v = longint'(c) + $signed($urandom_range(2 * span)) - span;
        return clamp(v);
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int span;
        int kind;
        kind = $urandom_range(9);
        span = (kind < 5) ? 4096 : 1 << $urandom_range(22, 2);
        p.ax = rand_word(); p.ay = rand_word();
        p.avx = ($urandom_range(7) == 0) ? rand_word() : near('0, 1 << $urandom_range(22, 1));
        p.avy = ($urandom_range(7) == 0) ? rand_word() : near('0, 1 << $urandom_range(22, 1));
        p.bvx = ($urandom_range(7) == 0) ? rand_word() : near('0, 1 << $urandom_range(22, 1));
        p.bvy = ($urandom_range(7) == 0) ? rand_word() : near('0, 1 << $urandom_range(22, 1));
        p.afix = ($urandom_range(3) == 0);
        p.bfix = ($urandom_range(3) == 0);
        if (kind == 9) begin
            p.bx = rand_word(); p.by = rand_word();
            p.ar = (W-1)'($urandom); p.br = (W-1)'($urandom);
        end else begin
            p.bx = near(p.ax, span); p.by = near(p.ay, span);
            p.ar = (W-1)'($urandom_range(span));
            p.br = (W-1)'($urandom_range(span));
            if ($urandom_range(15) == 0) begin
                p.bx = p.ax; p.by = p.ay;
            end
        end
        return p;
    endfunction

    function automatic pair_t make_pair(int ax, int ay, int avx, int avy, int ar,
                                        int bx, int by, int bvx, int bvy, int br,
                                        bit af, bit bf);
        pair_t p;
        p.ax = W'(ax); p.ay = W'(ay); p.avx = W'(avx); p.avy = W'(avy);
        p.ar = (W-1)'(ar); p.afix = af;
        p.bx = W'(bx); p.by = W'(by); p.bvx = W'(bvx); p.bvy = W'(bvy);
        p.br = (W-1)'(br); p.bfix = bf;
        return p;
    endfunction

    task automatic apb_write(logic [CFG_AW-1:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        bounce_model = data[BOUNCE_W-1:0];
    endtask

    task automatic run_phase(int n_random);
        longint lo, hi;
        lo = -(longint'(1) <<< (W - 1));
        hi = (longint'(1) <<< (W - 1)) - 1;
        if (n_random < 0) begin
            pending_pairs.push_back(make_pair(0, 0, 256, 0, 512, 768, 0, -256, 0, 512, 0, 0));
            pending_pairs.push_back(make_pair(0, 0, 256, 0, 512, 768, 0, -256, 0, 512, 1, 0));
            pending_pairs.push_back(make_pair(0, 0, 256, 0, 512, 768, 0, -256, 0, 512, 0, 1));
            pending_pairs.push_back(make_pair(0, 0, 256, 0, 512, 768, 0, -256, 0, 512, 1, 1));
            pending_pairs.push_back(make_pair(0, 0, -256, 0, 512, 768, 0, 256, 0, 512, 0, 0));
            pending_pairs.push_back(make_pair(0, 0, 0, 0, 512, 768, 0, 0, 0, 512, 0, 0));
            pending_pairs.push_back(make_pair(100, 100, 256, 9, 512, 100, 100, -256, 0, 512, 0, 0));
            pending_pairs.push_back(make_pair(0, 0, 256, 0, 100, 5000, 0, -256, 0, 100, 0, 0));
            pending_pairs.push_back(make_pair(0, 0, 300, 300, 400, 300, 300, 0, 0, 400, 0, 0));
            pending_pairs.push_back(make_pair(0, 0, 1, 0, 512, 768, 0, 0, 0, 512, 0, 0));
            pending_pairs.push_back(make_pair(0, 0, int'(hi), int'(hi), 2, 1, 1,
                                              int'(lo), int'(lo), 2, 0, 0));
            pending_pairs.push_back(make_pair(0, 0, int'(hi), 0, 2, 1, 0, int'(lo), 0, 2, 1, 0));
            pending_pairs.push_back(make_pair(int'(lo), int'(lo), 0, 0, int'(hi >>> 0) & 8388607,
                                              int'(hi), int'(hi), int'(lo), int'(lo),
                                              8388607, 0, 0));
            pending_pairs.push_back(make_pair(int'(hi), int'(lo), int'(lo), int'(hi), 8388607,
                                              int'(lo), int'(hi), int'(hi), int'(lo),
                                              8388607, 0, 1));
            pending_pairs.push_back(make_pair(int'(lo), 0, 0, 0, 0, int'(hi), 0, 0, 0, 0, 0, 0));
        end else begin
            repeat (n_random) pending_pairs.push_back(random_pair());
        end
        driver_on = 1'b1;
        wait (pending_pairs.size() == 0 && expected_responses.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    initial begin
        logic [BOUNCE_W-1:0] settings[6];
        settings = '{15'd0, 15'd32767, 15'd16384, 15'd8192, 15'd1, 15'd0};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_phase(-1);
        run_phase(200);
        foreach (settings[k]) begin
            settings[k] = (k == 5) ? BOUNCE_W'($urandom) : settings[k];
            apb_write({REG_BOUNCE, 2'b00}, {17'd0, settings[k]});
            run_phase(-1);
            run_phase(180);
        end
        $display("Checked %0d words over %0d bounciness settings.", words_checked, 7);
        $display("Touching pairs: %0d, responding pairs: %0d.", touches_seen, responses_seen);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
